/* rtl/core/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/core/rmod_pkg.sv */
package rmod_pkg;

   localparam int PHASE_BITS       = 24;
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int SAMPLE_BITS      = 16;
   localparam int FRAC_BITS        = SAMPLE_BITS - 1;
   localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
   localparam int LUT_BITS         = (SINE_TABLE_DEPTH + 1) * FRAC_BITS;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [31:0] LFSR_TAPS   = 32'h8020_0003;
   localparam logic [31:0] LFSR_SEED   = 32'h0000_0001;

   // register indexes
   localparam logic [2:0] REG_CARRIER_STEP   = 3'd0;
   localparam logic [2:0] REG_MODULATOR_STEP = 3'd1;
   localparam logic [2:0] REG_DEPTH          = 3'd2;
   localparam logic [2:0] REG_WAVE_SELECT    = 3'd3;
   localparam logic [2:0] REG_WET            = 3'd4;
   localparam logic [2:0] REG_BYPASS         = 3'd5;

   // wave codes
   localparam logic [2:0] WAVE_SINE     = 3'd0;
   localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
   localparam logic [2:0] WAVE_SAW      = 3'd2;
   localparam logic [2:0] WAVE_SQUARE   = 3'd3;
   localparam logic [2:0] WAVE_NOISE    = 3'd4;

   localparam int TANH_LAST = 12;

   // quarter-wave table, Q30 taylor series rescaled to the sample format
   function automatic logic [LUT_BITS-1:0] build_sine();
      logic [LUT_BITS-1:0] lut;
      logic [63:0]         x;
      logic [63:0]         x2;
      logic [63:0]         t;
      logic [63:0]         q;
      logic signed [63:0]  sum;
      logic [63:0]         e;
      lut = '0;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x   = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
         x2  = (x * x) >> 30;
         t   = x;
         sum = signed'(x);
         for (int k = 1; k <= 7; k++) begin
            q = (t * x2) >> 30;
            case (k)
               1: t = q / 64'd6;
               2: t = q / 64'd20;
               3: t = q / 64'd42;
               4: t = q / 64'd72;
               5: t = q / 64'd110;
               6: t = q / 64'd156;
               default: t = q / 64'd210;
            endcase
            if (k % 2 == 1) sum = sum - signed'(t);
            else sum = sum + signed'(t);
         end
         if (sum < 0) sum = 0;
         e = (64'(sum) * ((64'd1 << FRAC_BITS) - 64'd1) + (64'd1 << 29)) >> 30;
         if (e > ((64'd1 << FRAC_BITS) - 64'd1)) e = (64'd1 << FRAC_BITS) - 64'd1;
         lut[i*FRAC_BITS +: FRAC_BITS] = e[FRAC_BITS-1:0];
      end
      return lut;
   endfunction

   localparam logic [LUT_BITS-1:0] SINE_LUT = build_sine();

   function automatic logic signed [SAMPLE_BITS-1:0] sine_at(input logic [PHASE_BITS-1:0] p);
      logic [1:0]                  quad;
      logic [SINE_IDX_BITS:0]      idx;
      logic [SINE_IDX_BITS:0]      tix;
      logic signed [SAMPLE_BITS-1:0] v;
      quad = p[PHASE_BITS-1 -: 2];
      idx  = {1'b0, p[PHASE_BITS-3 -: SINE_IDX_BITS]};
      tix  = quad[0] ? (SINE_IDX_BITS+1)'(SINE_TABLE_DEPTH) - idx : idx;
      v    = signed'({1'b0, SINE_LUT[tix*FRAC_BITS +: FRAC_BITS]});
      return quad[1] ? -v : v;
   endfunction

   // tanh(1 + k/4) in Q1.15
   function automatic logic [15:0] tanh_at(input logic [3:0] k);
      case (k)
         4'd0:  return 16'd24956;
         4'd1:  return 16'd27797;
         4'd2:  return 16'd29660;
         4'd3:  return 16'd30847;
         4'd4:  return 16'd31589;
         4'd5:  return 16'd32048;
         4'd6:  return 16'd32329;
         4'd7:  return 16'd32501;
         4'd8:  return 16'd32606;
         4'd9:  return 16'd32670;
         4'd10: return 16'd32708;
         4'd11: return 16'd32732;
         default: return 16'd32746;
      endcase
   endfunction

endpackage

/* rtl/core/ring_modulator_with_lfo.sv */
// ring modulator with lfo-shaped depth and dry/wet mix
//
// req channel: one Q1.15 sample per word, taken when req_valid is high and
// req_stall low. rsp channel: one Q1.15 sample per word, held in an output
// register until rsp_stall is low.
// csr channel: csr_index 0..5 selects carrier_step, modulator_step, depth,
// wave_select, wet, bypass; csr_ready is always high, write only while idle.
//
// steps: a taken sample passes through wave, mul1..mul6, mix, clip1, clip2
// and fin before its result is written; the block takes no new sample until
// it is back in idle. all products go through one 18x18 signed multiplier,
// one product per step. in bypass the sample goes through the byp step only.
// the final step waits while an earlier result is still stalled, and
// req_stall stays high until it can write the output register.
//
// reset: phases clear, the noise lfsr loads 1, depth and wet load 0.5,
// wave is sine, bypass off, no result pending.
module ring_modulator_with_lfo
   import rmod_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [23:0]                   csr_data
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_BYP   = 4'd1;
   localparam logic [3:0] S_WAVE  = 4'd2;
   localparam logic [3:0] S_MUL1  = 4'd3;
   localparam logic [3:0] S_MUL2  = 4'd4;
   localparam logic [3:0] S_MUL3  = 4'd5;
   localparam logic [3:0] S_MUL4  = 4'd6;
   localparam logic [3:0] S_MUL5  = 4'd7;
   localparam logic [3:0] S_MUL6  = 4'd8;
   localparam logic [3:0] S_MIX   = 4'd9;
   localparam logic [3:0] S_CLIP1 = 4'd10;
   localparam logic [3:0] S_CLIP2 = 4'd11;
   localparam logic [3:0] S_FIN   = 4'd12;

   function automatic logic signed [21:0] rnd15(input logic signed [36:0] v);
      logic signed [36:0] s;
      s = v + 37'sd16384;
      return s[36:15];
   endfunction

   // config
   logic [23:0] carrier_step_ff, modulator_step_ff;
   logic [15:0] depth_ff, wet_ff;
   logic [2:0]  wave_ff;
   logic        bypass_ff;

   // state
   logic [3:0]            state_ff, state_in;
   logic [PHASE_BITS-1:0] car_phase_ff, car_phase_in;
   logic [PHASE_BITS-1:0] mod_phase_ff, mod_phase_in;
   logic [31:0]           lfsr_ff, lfsr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]    rsp_data_ff, rsp_data_in;

   // datapath
   logic signed [15:0] x_ff, x_in;
   logic signed [15:0] c_ff, c_in;
   logic signed [17:0] m_ff, m_in;
   logic signed [17:0] modamt_ff, modamt_in;
   logic signed [16:0] r1_ff, r1_in;
   logic signed [17:0] ring_ff, ring_in;
   logic signed [35:0] acc_ff, acc_in;
   logic signed [35:0] prod_ff, prod_in;
   logic signed [21:0] y_ff, y_in;
   logic [21:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic               big_ff, big_in;
   logic [15:0]        base_ff, base_in;

   logic signed [17:0] mul_a, mul_b;
   logic signed [17:0] wave_m;
   logic [31:0]        lfsr_next;
   logic [16:0]        u;
   logic               out_free;
   logic [21:0]        off;
   logic [15:0]        tanh_a, tanh_b;
   logic [21:0]        clip_val;
   logic signed [22:0] sval;
   logic signed [15:0] sat_val;
   logic signed [21:0] prod_rnd;

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;
   assign csr_ready      = 1'b1;
   assign out_free       = !rsp_valid_ff || !rsp_stall;

   // last product rescaled by 2^15, rounded half up
   assign prod_rnd = rnd15(37'(prod_ff));

   // modulator wave
   always_comb begin
      lfsr_next = {1'b0, lfsr_ff[31:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : 32'd0);
      u = mod_phase_ff[PHASE_BITS-1 -: 17];
      case (wave_ff)
         WAVE_SINE:     wave_m = 18'(sine_at(mod_phase_ff));
         WAVE_TRIANGLE: wave_m = u[16] ? 18'sd98304 - signed'({1'b0, u})
                                       : signed'({1'b0, u}) - 18'sd32768;
         WAVE_SAW:      wave_m = signed'({2'b00, u[16:1]}) - 18'sd32768;
         WAVE_SQUARE:   wave_m = u[16] ? -18'sd32768 : 18'sd32768;
         WAVE_NOISE:    wave_m = signed'({2'b00, lfsr_next[31:16]}) - 18'sd32768;
         default:       wave_m = '0;
      endcase
   end

   // soft clip segment
   always_comb begin
      off    = mag_ff - 22'd32768;
      tanh_a = tanh_at(off[16:13]);
      tanh_b = tanh_at(off[16:13] + 4'd1);
   end

   // final value, sign and saturation
   always_comb begin
      clip_val = big_ff ? 22'(base_ff) + 22'(prod_ff[35:13]) : mag_ff;
      sval     = neg_ff ? -signed'({1'b0, clip_val}) : signed'({1'b0, clip_val});
      if (sval > 23'sd32767) sat_val = 16'sh7fff;
      else if (sval < -23'sd32768) sat_val = -16'sh8000;
      else sat_val = sval[15:0];
   end

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         S_MUL1:  begin mul_a = m_ff;           mul_b = signed'({2'b00, depth_ff}); end
         S_MUL2:  begin mul_a = 18'(x_ff);      mul_b = 18'(c_ff); end
         S_MUL3:  begin mul_a = 18'(x_ff);
                        mul_b = 18'sd32768 - signed'({2'b00, wet_ff}); end
         S_MUL4:  begin mul_a = 18'(r1_ff);     mul_b = modamt_ff; end
         S_MUL6:  begin mul_a = ring_ff;        mul_b = signed'({2'b00, wet_ff}); end
         S_CLIP2: begin
            mul_a = signed'({2'b00, tanh_b - tanh_a});
            mul_b = (off[21:13] >= 9'(TANH_LAST)) ? 18'sd0 : signed'({5'b0, off[12:0]});
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      car_phase_in = car_phase_ff;
      mod_phase_in = mod_phase_ff;
      lfsr_in      = lfsr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      x_in         = x_ff;
      c_in         = c_ff;
      m_in         = m_ff;
      modamt_in    = modamt_ff;
      r1_in        = r1_ff;
      ring_in      = ring_ff;
      acc_in       = acc_ff;
      prod_in      = mul_a * mul_b;
      y_in         = y_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      big_in       = big_ff;
      base_in      = base_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in     = req_sample_in;
               state_in = bypass_ff ? S_BYP : S_WAVE;
            end
         end
         S_BYP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = x_ff;
               state_in     = S_IDLE;
            end
         end
         S_WAVE: begin
            c_in         = sine_at(car_phase_ff);
            m_in         = wave_m;
            car_phase_in = car_phase_ff + carrier_step_ff;
            mod_phase_in = mod_phase_ff + modulator_step_ff;
            if (wave_ff == WAVE_NOISE) lfsr_in = lfsr_next;
            state_in     = S_MUL1;
         end
         S_MUL1: state_in = S_MUL2;
         S_MUL2: begin
            modamt_in = 18'sd32768 + signed'(prod_rnd[17:0]);
            state_in  = S_MUL3;
         end
         S_MUL3: begin
            r1_in    = prod_rnd[16:0];
            state_in = S_MUL4;
         end
         S_MUL4: begin
            acc_in   = prod_ff;
            state_in = S_MUL5;
         end
         S_MUL5: begin
            ring_in  = prod_rnd[17:0];
            state_in = S_MUL6;
         end
         S_MUL6: state_in = S_MIX;
         S_MIX: begin
            y_in     = rnd15(37'(acc_ff) + 37'(prod_ff));
            state_in = S_CLIP1;
         end
         S_CLIP1: begin
            neg_in   = y_ff[21];
            mag_in   = y_ff[21] ? 22'(-y_ff) : 22'(y_ff);
            state_in = S_CLIP2;
         end
         S_CLIP2: begin
            big_in   = mag_ff > 22'd32768;
            // past the last segment the curve holds flat
            base_in  = (off[21:13] >= 9'(TANH_LAST)) ? tanh_at(4'(TANH_LAST)) : tanh_a;
            state_in = S_FIN;
         end
         S_FIN: begin
            prod_in = prod_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat_val;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         car_phase_ff      <= '0;
         mod_phase_ff      <= '0;
         lfsr_ff           <= LFSR_SEED;
         rsp_valid_ff      <= 1'b0;
         carrier_step_ff   <= '0;
         modulator_step_ff <= '0;
         depth_ff          <= 16'd16384;
         wave_ff           <= WAVE_SINE;
         wet_ff            <= 16'd16384;
         bypass_ff         <= 1'b0;
      end else begin
         state_ff     <= state_in;
         car_phase_ff <= car_phase_in;
         mod_phase_ff <= mod_phase_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               REG_CARRIER_STEP:   carrier_step_ff   <= csr_data;
               REG_MODULATOR_STEP: modulator_step_ff <= csr_data;
               REG_DEPTH:          depth_ff          <= csr_data[15:0];
               REG_WAVE_SELECT:    wave_ff           <= csr_data[2:0];
               REG_WET:            wet_ff            <= csr_data[15:0];
               REG_BYPASS:         bypass_ff         <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      x_ff        <= x_in;
      c_ff        <= c_in;
      m_ff        <= m_in;
      modamt_ff   <= modamt_in;
      r1_ff       <= r1_in;
      ring_ff     <= ring_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      y_ff        <= y_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      big_ff      <= big_in;
      base_ff     <= base_in;
   end

endmodule

/* rtl/core/rmod_checker.sv */
`include "assert_macros.svh"

module rmod_checker
   import rmod_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample_out
);

   // a stalled result word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sample_out))

   // taking a word makes the block busy
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // a new result only comes out of a busy cycle
   `ASSERT_IMPLIES(a_result_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind ring_modulator_with_lfo rmod_checker u_rmod_checker (.*);
